FILE: hw/rtl/gbfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfp_pkg
// Shared types, byte codes and the crc-16-ccitt byte update for the parser.
// ----------------------------------------------------------------------------
package gbfp_pkg;

  localparam logic [7:0]  SYNC1_CHAR  = 8'h24;  // '$'
  localparam logic [7:0]  SYNC2_CHAR  = 8'h40;  // '@'
  localparam logic [7:0]  ACK_CHAR    = 8'h52;  // 'R'
  localparam logic [15:0] HEADER_LEN  = 16'd8;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_CRC_ERR = 3'd2,
    KIND_BAD_LEN = 3'd3,
    KIND_OVERRUN = 3'd4,
    KIND_ACK     = 3'd5
  } kind_t;

  typedef enum logic [8:0] {
    PH_SYNC1  = 9'b000000001,
    PH_SYNC2  = 9'b000000010,
    PH_CRC_LO = 9'b000000100,
    PH_CRC_HI = 9'b000001000,
    PH_ID_LO  = 9'b000010000,
    PH_ID_HI  = 9'b000100000,
    PH_LEN_LO = 9'b001000000,
    PH_LEN_HI = 9'b010000000,
    PH_DATA   = 9'b100000000
  } phase_t;

  // one result beat from the parser core
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  index;
    logic [15:0] block_id;
    logic [15:0] block_length;
    logic [15:0] err_count;
    logic        last;
  } result_t;

  // msb-first crc-16-ccitt over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/gnss_binary_frame_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_top
// Byte stream framer: sync hunt, command ack, header capture, length check, payload stream, crc check.
//
//   channel  dir  beat contents
//   s_*      in   tdata[7:0] rx_byte
//   m_*      out  tdata payload bytes/index/id/length/error count, tuser kind,
//                 tlast frame end
//
// One byte is taken every cycle while the result side does not stall; a result
// beat leaves after its byte passes the input register, then the result register.
// The per-byte crc update and phase step are combinational between them.
// Reset (rst, synchronous) clears the phase, header fields and error count.
// With m_tready low the result register holds and one more byte is buffered.
// ----------------------------------------------------------------------------
module gnss_binary_frame_parser_top #(
  parameter int MAX_PAYLOAD_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                 // [31:16] block_id, [47:32] block_length,
                                 // [63:48] crc_error_count
  output logic [2:0]  m_tuser,   // [2:0] event_kind
  output logic        m_tlast    // frame_last
);
  import gbfp_pkg::*;

  logic    advance;
  logic    byte_valid;
  logic [7:0] byte_data;
  result_t res;
  result_t out_reg;
  logic    out_valid;

  assign advance = !out_valid || m_tready;

  gbfp_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .advance   (advance),
    .byte_valid(byte_valid),
    .byte_data (byte_data)
  );

  gbfp_core #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (byte_valid && advance),
    .rx_byte(byte_data),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= byte_valid && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && byte_valid && res.valid) begin
      out_reg <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_reg.err_count, out_reg.block_length, out_reg.block_id,
                     out_reg.index, out_reg.data};
  assign m_tuser  = out_reg.kind;
  assign m_tlast  = out_reg.last;

  a_payload_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_PAYLOAD |-> !m_tlast)
    else $error("payload beat marked as frame end");

  a_ack_no_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ACK |-> m_tdata[47:0] == 48'd0 && !m_tlast)
    else $error("command ack carries block fields");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= KIND_ACK)
    else $error("result kind out of range");

endmodule

FILE: hw/rtl/gbfp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfp_in_reg
// Input register for received bytes; holds one beat while the result side stalls.
// ----------------------------------------------------------------------------
module gbfp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       full;
  logic       full_next;
  logic [7:0] data;
  logic       take;

  assign s_tready = !full || advance;
  assign take     = s_tvalid && s_tready;

  always_comb begin
    full_next = full;
    if (take) begin
      full_next = 1'b1;
    end else if (advance) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data <= s_tdata;
    end
  end

  assign byte_valid = full;
  assign byte_data  = data;

endmodule

FILE: hw/rtl/gbfp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfp_core
// Frame state machine, header capture, running crc and payload counting.
// ----------------------------------------------------------------------------
module gbfp_core #(
  parameter int MAX_PAYLOAD_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output gbfp_pkg::result_t res
);
  import gbfp_pkg::*;

  localparam int CW = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PAYLOAD_BYTES);

  phase_t        phase, phase_next;
  logic [15:0]   rx_crc, rx_crc_next;
  logic [15:0]   id_reg, id_reg_next;
  logic [15:0]   len_reg, len_reg_next;
  logic [CW-1:0] count, count_next;
  logic [15:0]   crc, crc_next;
  logic [15:0]   fail_total, fail_total_next;

  logic [15:0]   crc_upd;
  logic [15:0]   count_ext;
  logic [15:0]   count_inc;
  logic [15:0]   len_m8;

  assign crc_upd   = crc_byte(crc, rx_byte);
  assign count_ext = 16'(count);
  assign count_inc = count_ext + 16'd1;
  assign len_m8    = len_reg - HEADER_LEN;

  always_comb begin
    phase_next      = phase;
    rx_crc_next     = rx_crc;
    id_reg_next     = id_reg;
    len_reg_next    = len_reg;
    count_next      = count;
    crc_next        = crc;
    fail_total_next = fail_total;
    res             = '0;
    res.kind        = KIND_PAYLOAD;

    unique case (phase)
      PH_SYNC2: begin
        if (rx_byte == SYNC2_CHAR) begin
          phase_next = PH_CRC_LO;
          crc_next   = 16'h0000;
        end else begin
          phase_next = PH_SYNC1;
          if (rx_byte == ACK_CHAR) begin
            res.valid = 1'b1;
            res.kind  = KIND_ACK;
          end
        end
      end
      PH_CRC_LO: begin
        rx_crc_next = {8'h00, rx_byte};
        phase_next  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        rx_crc_next = {rx_byte, rx_crc[7:0]};
        phase_next  = PH_ID_LO;
      end
      PH_ID_LO: begin
        id_reg_next = {8'h00, rx_byte};
        crc_next    = crc_upd;
        phase_next  = PH_ID_HI;
      end
      PH_ID_HI: begin
        id_reg_next = {rx_byte, id_reg[7:0]};
        crc_next    = crc_upd;
        phase_next  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_reg_next = {8'h00, rx_byte};
        crc_next     = crc_upd;
        phase_next   = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_reg_next = {rx_byte, len_reg[7:0]};
        crc_next     = crc_upd;
        count_next   = '0;
        if (len_reg_next[1:0] != 2'b00 || len_reg_next <= HEADER_LEN) begin
          phase_next       = PH_SYNC1;
          res.valid        = 1'b1;
          res.kind         = KIND_BAD_LEN;
          res.block_id     = id_reg_next;
          res.block_length = len_reg_next;
          res.last         = 1'b1;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        res.valid        = 1'b1;
        res.block_id     = id_reg;
        res.block_length = len_reg;
        if (count >= CNT_MAX) begin
          phase_next = PH_SYNC1;
          res.kind   = KIND_OVERRUN;
          res.last   = 1'b1;
        end else begin
          crc_next   = crc_upd;
          count_next = count + CW'(1);
          res.data   = rx_byte;
          res.index  = count_ext[7:0];
          if (count_inc >= len_m8) begin
            phase_next = PH_SYNC1;
            res.last   = 1'b1;
            if (crc_upd == rx_crc) begin
              res.kind = KIND_GOOD;
            end else begin
              res.kind        = KIND_CRC_ERR;
              fail_total_next = fail_total + 16'd1;
            end
          end
        end
      end
      default: begin
        if (rx_byte == SYNC1_CHAR) begin
          phase_next = PH_SYNC2;
          count_next = '0;
        end else begin
          phase_next = PH_SYNC1;
        end
      end
    endcase
    res.err_count = fail_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SYNC1;
      rx_crc     <= '0;
      id_reg     <= '0;
      len_reg    <= '0;
      count      <= '0;
      crc        <= '0;
      fail_total <= '0;
    end else if (step) begin
      phase      <= phase_next;
      rx_crc     <= rx_crc_next;
      id_reg     <= id_reg_next;
      len_reg    <= len_reg_next;
      count      <= count_next;
      crc        <= crc_next;
      fail_total <= fail_total_next;
    end
  end

  // error total moves only by one, and only on a crc failure
  a_fail_step: assert property (@(posedge clk) disable iff (rst)
    fail_total != $past(fail_total) |-> fail_total == $past(fail_total) + 16'd1)
    else $error("crc failure total jumped");

  a_fail_on_err: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && res.kind == KIND_CRC_ERR |=> fail_total == $past(fail_total) + 16'd1)
    else $error("crc error not counted");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("payload count beyond buffer size");

  a_data_meta: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_DATA |=> phase == PH_DATA || phase == PH_SYNC1)
    else $error("data phase left to an unexpected phase");

endmodule
